@@ rtl/sew_pkg.sv @@
package sew_pkg;

  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned WordW = 32;
  localparam int unsigned InW = 9 * WordW;
  localparam int unsigned OutW = 12 * WordW;

  // Radians to phase in 2^-32 turn: round(2^32 / (2*pi)).
  localparam logic signed [31:0] TurnPerRad = 32'sd683565276;

  localparam logic signed [33:0] Q30One = 34'sd1073741824;
  localparam logic signed [33:0] SinC1 = 34'sd1686629713;
  localparam logic signed [33:0] SinC3 = -34'sd693598669;
  localparam logic signed [33:0] SinC5 = 34'sd85569306;
  localparam logic signed [33:0] SinC7 = -34'sd5026995;
  localparam logic signed [33:0] SinC9 = 34'sd172272;

  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  typedef struct packed {
    logic signed [31:0] scl_x;
    logic signed [31:0] scl_y;
    logic signed [31:0] scl_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } side_t;

  // Q30 product, magnitude truncated toward zero.
  function automatic logic signed [39:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic neg;
    logic [33:0] ua;
    logic [33:0] ub;
    logic [67:0] p;
    logic [39:0] m;
    neg = a[33] ^ b[33];
    ua = a[33] ? 34'(-a) : 34'(a);
    ub = b[33] ? 34'(-b) : 34'(b);
    p = ua * ub;
    m = {2'b00, p[67:30]};
    mul_q30 = neg ? $signed(-m) : $signed(m);
  endfunction

endpackage

@@ rtl/scale_euler_world_matrix_core.sv @@
// World matrix from per-object scale, Euler angles (radians) and position.
//
// Request channel s_axis_*: one request carries nine signed Q16.16 words,
// scale x/y/z, angle x/y/z, position x/y/z, packed lowest first in tdata.
// Result channel m_axis_*: twelve words, m00..m22 each saturated to the
// 32-bit range, then the translation row m30..m32 passed through unchanged.
//
// From acceptance to m_axis_tvalid a request passes the phase multiply,
// the polynomial sine/cosine (at most one multiply per stage), then pair
// products, triple products, scaling and saturation. Throughput is one
// request per cycle while results are taken; each stage holds its own
// valid bit, so a stage advances when the one after it is empty or moving.
//
// When the receiver stalls, the result holds in the output register and the
// stages behind it keep filling until every stage is occupied; only then is
// s_axis_tready lowered. Nothing is dropped or repeated.
// Reset clears all valid bits; the pipeline is empty and ready at once.
module scale_euler_world_matrix_core #(
  parameter int unsigned FRAC_BITS = sew_pkg::FracBitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, pos_x, pos_y, pos_z
  input  logic [sew_pkg::InW-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, m30, m31, m32
  output logic [sew_pkg::OutW-1:0] m_axis_tdata
);

  localparam int unsigned NStage = 12;

  logic [NStage:1]  v_q;
  logic [NStage+1:1] en;
  sew_pkg::side_t   side_d;
  sew_pkg::side_t   side_q [1:NStage];
  logic [31:0]      ph [3];
  logic signed [31:0] sn [3];
  logic signed [31:0] cs [3];
  logic signed [31:0] m [9];

  // Stage k advances when empty or when stage k+1 advances.
  always_comb begin
    en[NStage+1] = m_axis_tready;
    for (int k = NStage; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = v_q[NStage];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= s_axis_tvalid;
      for (int k = 2; k <= NStage; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Carry scale and position alongside the arithmetic.
  assign side_d.scl_x = s_axis_tdata[31:0];
  assign side_d.scl_y = s_axis_tdata[63:32];
  assign side_d.scl_z = s_axis_tdata[95:64];
  assign side_d.pos_x = s_axis_tdata[223:192];
  assign side_d.pos_y = s_axis_tdata[255:224];
  assign side_d.pos_z = s_axis_tdata[287:256];

  always_ff @(posedge clk_i) begin
    if (en[1]) side_q[1] <= side_d;
    for (int k = 2; k <= NStage; k++) begin
      if (en[k]) side_q[k] <= side_q[k-1];
    end
  end

  for (genvar a = 0; a < 3; a++) begin : g_axis
    sew_phase #(.FRAC_BITS(FRAC_BITS)) u_phase (
      .clk_i   (clk_i),
      .en_i    (en[1]),
      .angle_i (s_axis_tdata[96 + 32*a +: 32]),
      .phase_o (ph[a])
    );
    sew_sincos u_sin (
      .clk_i   (clk_i),
      .en_i    (en[8:2]),
      .phase_i (ph[a]),
      .sin_o   (sn[a])
    );
    sew_sincos u_cos (
      .clk_i   (clk_i),
      .en_i    (en[8:2]),
      .phase_i (ph[a] + sew_pkg::QuarterTurn),
      .sin_o   (cs[a])
    );
  end

  sew_matrix u_matrix (
    .clk_i   (clk_i),
    .en_i    (en[12:9]),
    .sx_i    (sn[0]),
    .cx_i    (cs[0]),
    .sy_i    (sn[1]),
    .cy_i    (cs[1]),
    .sz_i    (sn[2]),
    .cz_i    (cs[2]),
    .scl_x_i (side_q[10].scl_x),
    .scl_y_i (side_q[10].scl_y),
    .scl_z_i (side_q[10].scl_z),
    .m_o     (m)
  );

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m_axis_tdata[32*k +: 32] = m[k];
    end
    m_axis_tdata[319:288] = side_q[NStage].pos_x;
    m_axis_tdata[351:320] = side_q[NStage].pos_y;
    m_axis_tdata[383:352] = side_q[NStage].pos_z;
  end

  // Back-pressure reaches the input only with a full output register.
  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid) else $error("input stalled with output empty");

  // A taking receiver never blocks the input.
  a_take_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready) else $error("input stalled while output drains");

  // A new result comes only from the stage before the output.
  a_result_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(v_q[NStage-1])) else $error("result without source");

endmodule

@@ rtl/sew_phase.sv @@
module sew_phase #(
  parameter int unsigned FRAC_BITS = sew_pkg::FracBitsDefault
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] angle_i,
  output logic        [31:0] phase_o
);

  logic signed [63:0] prod_d;
  logic        [31:0] phase_q;

  assign prod_d = 64'(angle_i) * 64'(sew_pkg::TurnPerRad);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_q <= prod_d[FRAC_BITS +: 32];
    end
  end

  assign phase_o = phase_q;

endmodule

@@ rtl/sew_sincos.sv @@
module sew_sincos (
  input  logic               clk_i,
  input  logic [6:0]         en_i,
  input  logic [31:0]        phase_i,
  output logic signed [31:0] sin_o
);

  logic [1:0]          quad_q [6];
  logic [30:0]         x_q [6];
  logic [30:0]         x_d;
  logic [30:0]         x2_q [4];
  logic signed [33:0]  t_q [4];
  logic signed [39:0]  tp [4];
  logic signed [33:0]  xs;
  logic signed [39:0]  s_raw;
  logic signed [31:0]  s_clamp;
  logic signed [31:0]  sin_q;
  logic signed [39:0]  x2_raw;

  // Fold odd quadrants onto the rising slope.
  assign x_d = phase_i[30] ? (31'h4000_0000 - {1'b0, phase_i[29:0]}) : {1'b0, phase_i[29:0]};
  assign xs = $signed({3'b000, x_q[5]});
  assign x2_raw = sew_pkg::mul_q30($signed({3'b000, x_q[0]}), $signed({3'b000, x_q[0]}));
  assign s_raw = sew_pkg::mul_q30(t_q[3], xs);

  // Horner steps, each with x^2 of its own request.
  assign tp[0] = sew_pkg::mul_q30(sew_pkg::SinC9, $signed({3'b000, x2_q[0]}));
  assign tp[1] = sew_pkg::mul_q30(t_q[0], $signed({3'b000, x2_q[1]}));
  assign tp[2] = sew_pkg::mul_q30(t_q[1], $signed({3'b000, x2_q[2]}));
  assign tp[3] = sew_pkg::mul_q30(t_q[2], $signed({3'b000, x2_q[3]}));

  always_comb begin
    if (s_raw < 40'sd0) begin
      s_clamp = '0;
    end else if (s_raw > 40'(sew_pkg::Q30One)) begin
      s_clamp = 32'(sew_pkg::Q30One);
    end else begin
      s_clamp = s_raw[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      quad_q[0] <= phase_i[31:30];
      x_q[0] <= x_d;
    end
    for (int k = 1; k < 6; k++) begin
      if (en_i[k]) quad_q[k] <= quad_q[k-1];
    end
    for (int k = 1; k < 6; k++) begin
      if (en_i[k]) x_q[k] <= x_q[k-1];
    end
    if (en_i[1]) x2_q[0] <= x2_raw[30:0];
    for (int k = 1; k < 4; k++) begin
      if (en_i[k+1]) x2_q[k] <= x2_q[k-1];
    end
    if (en_i[2]) t_q[0] <= sew_pkg::SinC7 + $signed(tp[0][33:0]);
    if (en_i[3]) t_q[1] <= sew_pkg::SinC5 + $signed(tp[1][33:0]);
    if (en_i[4]) t_q[2] <= sew_pkg::SinC3 + $signed(tp[2][33:0]);
    if (en_i[5]) t_q[3] <= sew_pkg::SinC1 + $signed(tp[3][33:0]);
    if (en_i[6]) sin_q <= quad_q[5][1] ? -s_clamp : s_clamp;
  end

  assign sin_o = sin_q;

endmodule

@@ rtl/sew_matrix.sv @@
module sew_matrix (
  input  logic               clk_i,
  input  logic [3:0]         en_i,
  input  logic signed [31:0] sx_i,
  input  logic signed [31:0] cx_i,
  input  logic signed [31:0] sy_i,
  input  logic signed [31:0] cy_i,
  input  logic signed [31:0] sz_i,
  input  logic signed [31:0] cz_i,
  input  logic signed [31:0] scl_x_i,
  input  logic signed [31:0] scl_y_i,
  input  logic signed [31:0] scl_z_i,
  output logic signed [31:0] m_o [9]
);

  // Pair products: sxsy cxsy cycz cysz cxsz cxcz sxcy sxsz sxcz cxcy, and -sy.
  logic signed [32:0] p_q [11];
  logic signed [32:0] cz_q;
  logic signed [32:0] sz_q;
  logic signed [32:0] e_q [9];
  logic signed [39:0] v_q [9];
  logic signed [33:0] scl [3];

  function automatic logic signed [32:0] m2(input logic signed [32:0] a,
                                            input logic signed [32:0] b);
    logic signed [39:0] r;
    r = sew_pkg::mul_q30(34'(a), 34'(b));
    m2 = r[32:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      p_q[0] <= m2(33'(sx_i), 33'(sy_i));
      p_q[1] <= m2(33'(cx_i), 33'(sy_i));
      p_q[2] <= m2(33'(cy_i), 33'(cz_i));
      p_q[3] <= m2(33'(cy_i), 33'(sz_i));
      p_q[4] <= m2(33'(cx_i), 33'(sz_i));
      p_q[5] <= m2(33'(cx_i), 33'(cz_i));
      p_q[6] <= m2(33'(sx_i), 33'(cy_i));
      p_q[7] <= m2(33'(sx_i), 33'(sz_i));
      p_q[8] <= m2(33'(sx_i), 33'(cz_i));
      p_q[9] <= m2(33'(cx_i), 33'(cy_i));
      p_q[10] <= -33'(sy_i);
      cz_q <= 33'(cz_i);
      sz_q <= 33'(sz_i);
    end
    if (en_i[1]) begin
      e_q[0] <= p_q[2];
      e_q[1] <= p_q[3];
      e_q[2] <= p_q[10];
      e_q[3] <= m2(p_q[0], cz_q) - p_q[4];
      e_q[4] <= m2(p_q[0], sz_q) + p_q[5];
      e_q[5] <= p_q[6];
      e_q[6] <= m2(p_q[1], cz_q) + p_q[7];
      e_q[7] <= m2(p_q[1], sz_q) - p_q[8];
      e_q[8] <= p_q[9];
    end
    if (en_i[2]) begin
      for (int k = 0; k < 9; k++) begin
        v_q[k] <= sew_pkg::mul_q30(scl[k / 3], 34'(e_q[k]));
      end
    end
    if (en_i[3]) begin
      for (int k = 0; k < 9; k++) begin
        if (v_q[k] > 40'sd2147483647) begin
          m_o[k] <= 32'sh7FFF_FFFF;
        end else if (v_q[k] < -40'sd2147483648) begin
          m_o[k] <= 32'sh8000_0000;
        end else begin
          m_o[k] <= v_q[k][31:0];
        end
      end
    end
  end

  assign scl[0] = 34'(scl_x_i);
  assign scl[1] = 34'(scl_y_i);
  assign scl[2] = 34'(scl_z_i);

endmodule

@@ sim/sew_matrix_checker.sv @@
`timescale 1ns / 1ps

module sew_matrix_checker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  logic                     req_ready_i,
  input  logic [sew_pkg::InW-1:0]  req_data_i,
  input  logic                     mat_valid_i,
  input  logic                     mat_ready_i,
  input  logic [sew_pkg::OutW-1:0] mat_data_i,
  output int                       fail_count_o,
  output int                       pending_o
);
  localparam int FracBits = sew_pkg::FracBitsDefault;

  logic [sew_pkg::OutW-1:0] matrix_q[$];

  assign pending_o = matrix_q.size();

  function automatic longint q30_mul(longint a, longint b);
    logic neg;
    longint ua;
    longint ub;
    longint p;
    neg = (a < 0) != (b < 0);
    ua = a < 0 ? -a : a;
    ub = b < 0 ? -b : b;
    p = (ua * ub) >>> 30;
    return neg ? -p : p;
  endfunction

  function automatic logic [31:0] angle_phase(logic signed [31:0] ang);
    logic signed [63:0] prod;
    prod = 64'(ang) * 64'sd683565276;
    return 32'(prod >>> FracBits);
  endfunction

  function automatic longint poly_sine(logic [31:0] ph);
    longint x;
    longint x2;
    longint t;
    longint s;
    x = longint'(ph[29:0]);
    if (ph[30]) x = 64'sd1073741824 - x;
    x2 = q30_mul(x, x);
    t = 64'sd172272;
    t = -64'sd5026995 + q30_mul(t, x2);
    t = 64'sd85569306 + q30_mul(t, x2);
    t = -64'sd693598669 + q30_mul(t, x2);
    t = 64'sd1686629713 + q30_mul(t, x2);
    s = q30_mul(t, x);
    if (s < 0) s = 0;
    if (s > 64'sd1073741824) s = 64'sd1073741824;
    return ph[31] ? -s : s;
  endfunction

  function automatic logic [31:0] scaled_sat(logic signed [31:0] scl, longint e);
    longint v;
    v = q30_mul(longint'(scl), e);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic logic [sew_pkg::OutW-1:0] world_matrix(logic [sew_pkg::InW-1:0] d);
    logic signed [31:0] w[9];
    logic [31:0] p[3];
    longint sn[3];
    longint cs[3];
    longint sxsy;
    longint cxsy;
    longint e[9];
    logic [sew_pkg::OutW-1:0] r;
    for (int i = 0; i < 9; i++) w[i] = d[32*i +: 32];
    for (int i = 0; i < 3; i++) begin
      p[i] = angle_phase(w[3+i]);
      sn[i] = poly_sine(p[i]);
      cs[i] = poly_sine(p[i] + sew_pkg::QuarterTurn);
    end
    sxsy = q30_mul(sn[0], sn[1]);
    cxsy = q30_mul(cs[0], sn[1]);
    e[0] = q30_mul(cs[1], cs[2]);
    e[1] = q30_mul(cs[1], sn[2]);
    e[2] = -sn[1];
    e[3] = q30_mul(sxsy, cs[2]) - q30_mul(cs[0], sn[2]);
    e[4] = q30_mul(sxsy, sn[2]) + q30_mul(cs[0], cs[2]);
    e[5] = q30_mul(sn[0], cs[1]);
    e[6] = q30_mul(cxsy, cs[2]) + q30_mul(sn[0], sn[2]);
    e[7] = q30_mul(cxsy, sn[2]) - q30_mul(sn[0], cs[2]);
    e[8] = q30_mul(cs[0], cs[1]);
    for (int i = 0; i < 9; i++) r[32*i +: 32] = scaled_sat(w[i/3], e[i]);
    for (int i = 0; i < 3; i++) r[32*(9+i) +: 32] = w[6+i];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("error: %s", what);
    fail_count_o++;
  endtask

  initial fail_count_o = 0;

  always @(posedge clk_i) begin
    logic [sew_pkg::OutW-1:0] want;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) matrix_q.push_back(world_matrix(req_data_i));
      if (mat_valid_i && mat_ready_i) begin
        if (matrix_q.size() == 0) begin
          report_mismatch("matrix with no request outstanding");
        end else begin
          want = matrix_q.pop_front();
          for (int i = 0; i < 12; i++)
            if (mat_data_i[32*i +: 32] !== want[32*i +: 32])
              report_mismatch($sformatf("element %0d got %h want %h", i,
                                        mat_data_i[32*i +: 32], want[32*i +: 32]));
        end
      end
    end
  end
endmodule

@@ sim/tb_scale_euler_world_matrix_core.sv @@
`timescale 1ns / 1ps

module tb_scale_euler_world_matrix_core;

  localparam int RandomRequests = 850;
  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 80;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // scale_x, scale_y, scale_z, angle_x, angle_y, angle_z, pos_x, pos_y, pos_z
  logic [sew_pkg::InW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // m00, m01, m02, m10, m11, m12, m20, m21, m22, m30, m31, m32
  logic [sew_pkg::OutW-1:0] m_axis_tdata;
  int fail_count;
  int pending;
  int cycle_count;
  bit idle_free;   // stretch with no idling on either side
  bit hold_off;    // long receiver stall to fill the pipeline
  bit hold_go;     // start of the receiver stall

  scale_euler_world_matrix_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  sew_matrix_checker checker_i (
    .clk_i, .rst_ni,
    .req_valid_i(s_axis_tvalid), .req_ready_i(s_axis_tready), .req_data_i(s_axis_tdata),
    .mat_valid_i(m_axis_tvalid), .mat_ready_i(m_axis_tready), .mat_data_i(m_axis_tdata),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Abort the run on a hang.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("scale_euler_world_matrix_core: mismatch");
        $finish;
      end
    end
  end

  // Hold the receiver off once started, then release it.
  initial begin
    hold_off = 1'b0;
    wait (hold_go);
    @(negedge clk_i);
    hold_off = 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    hold_off = 1'b0;
  end

  // Receiver: random stalls, none during the free stretch, held low during hold-off.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else if (idle_free) m_axis_tready <= 1'b1;
      else m_axis_tready <= ($urandom_range(99) >= 37);
    end
  end

  // Pick a word biased towards extremes and small angles.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0001_0000;
      3: return 32'hffff_0000;
      4: return 32'(int'($urandom_range(13 << 16)) - (13 << 15));
      default: return $urandom;
    endcase
  endfunction

  // Offer one request and hold it until accepted.
  task automatic send_request(logic [sew_pkg::InW-1:0] d, bit may_idle);
    if (may_idle && !idle_free)
      while ($urandom_range(99) < 37) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [sew_pkg::InW-1:0] d;
    logic [31:0] directed_w[8];
    int settle;
    directed_w = '{32'h0, 32'h0001_0000, 32'h7fff_ffff, 32'h8000_0000,
                   32'hffff_ffff, 32'h0001_921f, 32'h0003_243f, 32'hfffe_6de1};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    idle_free = 1'b0;
    hold_go = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: zero, unit, extremes, minus one lsb, quarter and half turns.
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 2; j++) begin
        for (int f = 0; f < 9; f++)
          d[32*f +: 32] = (f < 3 || f >= 6) ? directed_w[(i + f) % 8]
                                           : directed_w[(i + f * j + f) % 8];
        send_request(d, 1'b1);
      end
    // Full-scale scales with angles at zero and with angle y at a quarter turn.
    for (int i = 0; i < 4; i++) begin
      for (int f = 0; f < 9; f++) d[32*f +: 32] = (f < 3) ? directed_w[2 + i % 2] : 32'h0;
      if (i >= 2) d[32*4 +: 32] = 32'h0001_921f;
      send_request(d, 1'b0);
    end

    for (int n = 0; n < RandomRequests; n++) begin
      idle_free = (n >= 200 && n < 300);
      if (n == 400) hold_go = 1'b1;
      for (int f = 0; f < 9; f++) d[32*f +: 32] = pick_word();
      // Keep offering without gaps while the receiver holds off.
      send_request(d, !(n >= 400 && n < 440));
    end
    idle_free = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    settle = 0;
    while (settle < 30) begin
      @(posedge clk_i);
      settle++;
    end
    if (fail_count == 0) $display("scale_euler_world_matrix_core: match");
    else $display("scale_euler_world_matrix_core: mismatch");
    $finish;
  end
endmodule

@@ files.f @@
rtl/sew_pkg.sv
rtl/sew_phase.sv
rtl/sew_sincos.sv
rtl/sew_matrix.sv
rtl/scale_euler_world_matrix_core.sv
sim/sew_matrix_checker.sv
sim/tb_scale_euler_world_matrix_core.sv
